// ===== rtl/bpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bpd_pkg
// Types, codes and the CRC-16-CCITT byte update shared by the deframer files.
// ----------------------------------------------------------------------------
`default_nettype none

package bpd_pkg;

  localparam int unsigned PIDX_W = 9;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned CRC_W  = 16;

  localparam logic [7:0]       HDR_BYTE = 8'h80;
  localparam logic [CRC_W-1:0] CRC_SEED = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]       PI_MASK  = 8'hF0;
  localparam logic [7:0]       PI_CLASS = 8'h50;

  localparam logic [7:0] RP_ACK  = 8'h00;
  localparam logic [7:0] RP_HDR  = 8'h51;
  localparam logic [7:0] RP_CRC  = 8'h52;
  localparam logic [7:0] RP_ZERO = 8'h53;
  localparam logic [7:0] RP_BIG  = 8'h54;

  typedef enum logic [2:0] {
    ST_ONGOING   = 3'd0,
    ST_ACCEPT    = 3'd1,
    ST_ACCEPT_PI = 3'd2,
    ST_BAD_HDR   = 3'd3,
    ST_ZERO      = 3'd4,
    ST_TOO_LONG  = 3'd5,
    ST_CRC_ERR   = 3'd6
  } status_e;

  typedef struct packed {
    status_e           status;
    logic              payload_valid;
    logic [PIDX_W-1:0] payload_index;
    logic [7:0]        payload_byte;
    logic [LEN_W-1:0]  packet_length;
    logic              reply_valid;
    logic [7:0]        reply_byte;
  } result_t;

  // Frame tracking status seen by the top level.
  typedef struct packed {
    logic at_header;
  } core_stat_t;

  // MSB-first CRC-16-CCITT update over one byte.
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0] data);
    logic [CRC_W-1:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc[CRC_W-1]) begin
        crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[CRC_W-2:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bootloader_packet_deframer_crc16.sv =====
// ----------------------------------------------------------------------------
// bootloader_packet_deframer_crc16
// Boot-loader link deframer with bytewise CRC-16-CCITT check.
// ----------------------------------------------------------------------------
// Each word on the slave stream is one received link byte (tdata[7:0]). For
// every byte exactly one result word leaves on the master stream, in order.
// The frame is header 0x80, a little-endian 16-bit length, the payload, and a
// little-endian CRC-16-CCITT (seed 0xFFFF). Payload bytes come out flagged
// with their index; the last byte of a frame, or a bad header or length,
// gives the outcome status and, where one is due, the reply byte to send.
// The block then waits for the next header.
// A byte is taken into an input register, decoded against the frame state in
// one pass, and lands in the result register; one byte per cycle is sustained
// while the receiver takes words. The rate is set by the one-pass update of
// the frame state (position, length and CRC).
// Reset empties both registers (their valid flags drop) and returns the frame
// state to header search with the CRC at its seed. When the receiver stalls,
// the result register holds its word and the input register fills; tready then
// drops until the receiver takes the word, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module bootloader_packet_deframer_crc16 #(
  parameter int unsigned MAX_PAYLOAD = 260
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[2:0], payload_index[11:3], payload_byte[19:12],
  // packet_length[35:20], reply_byte[43:36], zero[47:44]
  output logic [47:0]      m_axis_tdata,
  // payload_valid[0], reply_valid[1]
  output logic [1:0]       m_axis_tuser
);

  localparam int unsigned POS_W = $clog2(MAX_PAYLOAD + 5);

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                out_ready;
  logic                advance;
  bpd_pkg::result_t    core_result;
  bpd_pkg::core_stat_t core_stat;
  bpd_pkg::result_t    out_data;

  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  bpd_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .POS_W       (POS_W)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .result_o (core_result),
    .stat_o   (core_stat)
  );

  bpd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .data_i  (core_result),
    .take_i  (m_axis_tready),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .data_o  (out_data)
  );

  assign m_axis_tdata = {4'b0000, out_data.reply_byte, out_data.packet_length,
                         out_data.payload_byte, out_data.payload_index,
                         out_data.status};
  assign m_axis_tuser = {out_data.reply_valid, out_data.payload_valid};

`ifndef SYNTH
  // A finished outcome always sends the frame tracker back to header search.
  a_restart_after_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (core_result.status != bpd_pkg::ST_ONGOING) |=> core_stat.at_header)
    else $error("frame state not restarted after an outcome");

  // A payload byte is never reported together with an outcome or a reply.
  a_payload_is_ongoing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (out_data.status == bpd_pkg::ST_ONGOING) && !m_axis_tuser[1])
    else $error("payload word carries an outcome");

  // A reply is due only with an outcome other than an accepted PI command.
  a_reply_has_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      (out_data.status != bpd_pkg::ST_ONGOING) &&
      (out_data.status != bpd_pkg::ST_ACCEPT_PI))
    else $error("reply without a matching outcome");
`endif

endmodule

`default_nettype wire

// ===== rtl/bpd_core.sv =====
// ----------------------------------------------------------------------------
// bpd_core
// Frame state and the per-byte decode: position, length, running CRC, first
// payload byte, and the result for the byte being stepped.
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_core #(
  parameter int unsigned MAX_PAYLOAD = 260,
  parameter int unsigned POS_W       = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [7:0]          byte_i,
  output bpd_pkg::result_t         result_o,
  output bpd_pkg::core_stat_t      stat_o
);

  logic [POS_W-1:0]          pos_q, pos_d;
  logic [bpd_pkg::LEN_W-1:0] len_q, len_d;
  logic [bpd_pkg::CRC_W-1:0] crc_q, crc_d;
  logic [7:0]                crc_lo_q, crc_lo_d;
  logic [7:0]                first_q, first_d;

  logic [bpd_pkg::LEN_W:0]   pos_ext;
  logic [bpd_pkg::LEN_W:0]   crc_lo_pos;
  logic [bpd_pkg::LEN_W:0]   crc_hi_pos;
  logic [bpd_pkg::LEN_W-1:0] len_full;
  logic                      done;

  assign pos_ext    = (bpd_pkg::LEN_W+1)'(pos_q);
  assign crc_lo_pos = {1'b0, len_q} + 17'd3;
  assign crc_hi_pos = {1'b0, len_q} + 17'd4;
  assign len_full   = {byte_i, len_q[7:0]};

  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    first_d  = first_q;
    done     = 1'b0;
    result_o = '0;
    result_o.status = bpd_pkg::ST_ONGOING;

    priority if (pos_q == '0) begin
      if (byte_i != bpd_pkg::HDR_BYTE) begin
        result_o.status     = bpd_pkg::ST_BAD_HDR;
        result_o.reply_valid = 1'b1;
        result_o.reply_byte  = bpd_pkg::RP_HDR;
        done = 1'b1;
      end else begin
        pos_d = POS_W'(1);
      end
    end else if (pos_q == POS_W'(1)) begin
      len_d = {8'h00, byte_i};
      pos_d = POS_W'(2);
    end else if (pos_q == POS_W'(2)) begin
      len_d = len_full;
      if (len_full == '0) begin
        result_o.status      = bpd_pkg::ST_ZERO;
        result_o.reply_valid = 1'b1;
        result_o.reply_byte  = bpd_pkg::RP_ZERO;
        done = 1'b1;
      end else if (len_full > bpd_pkg::LEN_W'(MAX_PAYLOAD)) begin
        result_o.status      = bpd_pkg::ST_TOO_LONG;
        result_o.reply_valid = 1'b1;
        result_o.reply_byte  = bpd_pkg::RP_BIG;
        done = 1'b1;
      end else begin
        pos_d = POS_W'(3);
      end
    end else if (pos_ext == crc_lo_pos) begin
      crc_lo_d = byte_i;
      pos_d    = pos_q + POS_W'(1);
    end else if (pos_ext == crc_hi_pos) begin
      if ({byte_i, crc_lo_q} == crc_q) begin
        if ((first_q & bpd_pkg::PI_MASK) == bpd_pkg::PI_CLASS) begin
          result_o.status = bpd_pkg::ST_ACCEPT_PI;
        end else begin
          result_o.status      = bpd_pkg::ST_ACCEPT;
          result_o.reply_valid = 1'b1;
          result_o.reply_byte  = bpd_pkg::RP_ACK;
        end
      end else begin
        result_o.status      = bpd_pkg::ST_CRC_ERR;
        result_o.reply_valid = 1'b1;
        result_o.reply_byte  = bpd_pkg::RP_CRC;
      end
      done = 1'b1;
    end else begin
      result_o.payload_valid = 1'b1;
      result_o.payload_index = bpd_pkg::PIDX_W'(pos_q - POS_W'(3));
      result_o.payload_byte  = byte_i;
      if (pos_q == POS_W'(3)) begin
        first_d = byte_i;
      end
      crc_d = bpd_pkg::crc_feed(crc_q, byte_i);
      pos_d = pos_q + POS_W'(1);
    end

    // The final byte still reports the length it was checked against.
    result_o.packet_length = len_d;

    if (done) begin
      pos_d    = '0;
      len_d    = '0;
      crc_d    = bpd_pkg::CRC_SEED;
      crc_lo_d = '0;
      first_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      len_q    <= '0;
      crc_q    <= bpd_pkg::CRC_SEED;
      crc_lo_q <= '0;
      first_q  <= '0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      first_q  <= first_d;
    end
  end

  assign stat_o.at_header = (pos_q == '0);

endmodule

`default_nettype wire

// ===== rtl/bpd_out_reg.sv =====
// ----------------------------------------------------------------------------
// bpd_out_reg
// Result register of the deframer: holds one result word until the
// downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire bpd_pkg::result_t data_i,
  input  wire logic             take_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output bpd_pkg::result_t      data_o
);

  logic             valid_q;
  bpd_pkg::result_t data_q;

  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== tb/frame_outcome_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_outcome_checker
// Watches both streams of the deframer, predicts one result word per link
// byte and compares every result word against the oldest prediction.
// ----------------------------------------------------------------------------
module frame_outcome_checker #(
  parameter int unsigned MAX_PAYLOAD = 260
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [47:0] m_tdata_i,
  input  logic [1:0]  m_tuser_i,
  output int          fails_o,
  output int          pending_o,
  output int          payload_words_o,
  output int          accepts_o,
  output int          pi_accepts_o,
  output int          rejects_o
);

  // Frame tracking state of the prediction.
  int unsigned               frame_pos;
  logic [bpd_pkg::LEN_W-1:0] decl_len;
  logic [bpd_pkg::CRC_W-1:0] payload_crc;
  logic [7:0]                crc_lo;
  logic [7:0]                lead_byte;

  bpd_pkg::result_t predicted_words[$];

  int mismatches    = 0;
  int words_seen    = 0;
  int payload_words = 0;
  int accepts       = 0;
  int pi_accepts    = 0;
  int rejects       = 0;

  assign fails_o         = mismatches;
  assign pending_o       = predicted_words.size();
  assign payload_words_o = payload_words;
  assign accepts_o       = accepts;
  assign pi_accepts_o    = pi_accepts;
  assign rejects_o       = rejects;

  // CRC-16-CCITT, one data bit at a time from the MSB.
  function automatic logic [bpd_pkg::CRC_W-1:0] ccitt_next(
      input logic [bpd_pkg::CRC_W-1:0] crc, input logic [7:0] d);
    logic [bpd_pkg::CRC_W-1:0] c;
    logic                      fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[bpd_pkg::CRC_W-1] ^ d[i];
      c  = {c[bpd_pkg::CRC_W-2:0], 1'b0};
      if (fb) begin
        c = c ^ bpd_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic restart_frame();
    frame_pos   = 0;
    decl_len    = '0;
    payload_crc = bpd_pkg::CRC_SEED;
    crc_lo      = '0;
    lead_byte   = '0;
  endtask

  // Moves the frame state on by one link byte and queues the result it causes.
  task automatic advance_frame(input logic [7:0] b);
    bpd_pkg::result_t          r;
    logic                      done;
    logic [bpd_pkg::CRC_W-1:0] rx_crc;
    r    = '0;
    done = 1'b0;
    r.status = bpd_pkg::ST_ONGOING;
    if (frame_pos == 0) begin
      if (b != bpd_pkg::HDR_BYTE) begin
        r.status      = bpd_pkg::ST_BAD_HDR;
        r.reply_valid = 1'b1;
        r.reply_byte  = bpd_pkg::RP_HDR;
        done          = 1'b1;
      end else begin
        frame_pos = 1;
      end
    end else if (frame_pos == 1) begin
      decl_len  = {8'h00, b};
      frame_pos = 2;
    end else if (frame_pos == 2) begin
      decl_len[15:8] = b;
      if (decl_len == 0) begin
        r.status      = bpd_pkg::ST_ZERO;
        r.reply_valid = 1'b1;
        r.reply_byte  = bpd_pkg::RP_ZERO;
        done          = 1'b1;
      end else if (decl_len > MAX_PAYLOAD) begin
        r.status      = bpd_pkg::ST_TOO_LONG;
        r.reply_valid = 1'b1;
        r.reply_byte  = bpd_pkg::RP_BIG;
        done          = 1'b1;
      end else begin
        frame_pos = 3;
      end
    end else if (frame_pos == decl_len + 3) begin
      crc_lo    = b;
      frame_pos = frame_pos + 1;
    end else if (frame_pos == decl_len + 4) begin
      rx_crc = {b, crc_lo};
      if (rx_crc != payload_crc) begin
        r.status      = bpd_pkg::ST_CRC_ERR;
        r.reply_valid = 1'b1;
        r.reply_byte  = bpd_pkg::RP_CRC;
      end else if ((lead_byte & bpd_pkg::PI_MASK) == bpd_pkg::PI_CLASS) begin
        // PI class commands are accepted silently.
        r.status = bpd_pkg::ST_ACCEPT_PI;
      end else begin
        r.status      = bpd_pkg::ST_ACCEPT;
        r.reply_valid = 1'b1;
        r.reply_byte  = bpd_pkg::RP_ACK;
      end
      done = 1'b1;
    end else begin
      r.payload_valid = 1'b1;
      r.payload_index = bpd_pkg::PIDX_W'(frame_pos - 3);
      r.payload_byte  = b;
      if (frame_pos == 3) begin
        lead_byte = b;
      end
      payload_crc = ccitt_next(payload_crc, b);
      frame_pos   = frame_pos + 1;
      payload_words++;
    end
    r.packet_length = decl_len;
    case (r.status)
      bpd_pkg::ST_ACCEPT:    accepts++;
      bpd_pkg::ST_ACCEPT_PI: pi_accepts++;
      bpd_pkg::ST_ONGOING:   ;
      default:               rejects++;
    endcase
    if (done) begin
      restart_frame();
    end
    predicted_words.push_back(r);
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result word %0d: %s expected 0x%0h, got 0x%0h",
                 words_seen, field, want, got);
      end
    end
  endtask

  task automatic check_word();
    bpd_pkg::result_t want;
    if (predicted_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result word %0d arrived with nothing predicted: tdata 0x%0h tuser %0b",
                 words_seen, m_tdata_i, m_tuser_i);
      end
    end else begin
      want = predicted_words.pop_front();
      compare_field("status",        want.status,        m_tdata_i[2:0]);
      compare_field("payload_valid", want.payload_valid, m_tuser_i[0]);
      compare_field("payload_index", want.payload_index, m_tdata_i[11:3]);
      compare_field("payload_byte",  want.payload_byte,  m_tdata_i[19:12]);
      compare_field("packet_length", want.packet_length, m_tdata_i[35:20]);
      compare_field("reply_valid",   want.reply_valid,   m_tuser_i[1]);
      compare_field("reply_byte",    want.reply_byte,    m_tdata_i[43:36]);
      compare_field("padding",       0,                  m_tdata_i[47:44]);
    end
    words_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_frame();
      predicted_words.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        advance_frame(s_tdata_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        check_word();
      end
    end
  end

endmodule

// ===== tb/bootloader_packet_deframer_crc16_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bootloader_packet_deframer_crc16_test
// Feeds the deframer with directed and random link byte streams, mostly
// well-formed frames with random payloads plus noise and broken frames, under
// random sender gaps and receiver stalls; a separate checker judges each word.
// ----------------------------------------------------------------------------
module bootloader_packet_deframer_crc16_test;

  localparam int unsigned MAX_PAYLOAD  = 260;
  localparam int unsigned RANDOM_BYTES = 900;
  localparam int unsigned STALL_LIMIT  = 2000;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_HOLD,
    RX_CHOPPY
  } rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;

  int fails;
  int pending;
  int payload_words;
  int accepts;
  int pi_accepts;
  int rejects;

  int       bytes_sent  = 0;
  int       burst_left  = 0;
  int       idle_cycles = 0;
  int       rx_hold_cnt = 0;
  rx_mode_e rx_mode     = RX_FLOW;

  always #5 clk_i = ~clk_i;

  bootloader_packet_deframer_crc16 #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser)
  );

  frame_outcome_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_tvalid),
    .s_tready_i     (s_tready),
    .s_tdata_i      (s_tdata),
    .m_tvalid_i     (m_tvalid),
    .m_tready_i     (m_tready),
    .m_tdata_i      (m_tdata),
    .m_tuser_i      (m_tuser),
    .fails_o        (fails),
    .pending_o      (pending),
    .payload_words_o(payload_words),
    .accepts_o      (accepts),
    .pi_accepts_o   (pi_accepts),
    .rejects_o      (rejects)
  );

  // The receiver switches between free flow, hard stalls and a choppy mix.
  always @(posedge clk_i) begin
    if (rx_hold_cnt == 0) begin
      rx_mode     = rx_mode_e'($urandom_range(0, 2));
      rx_hold_cnt = (rx_mode == RX_HOLD) ? $urandom_range(1, 16) : $urandom_range(1, 40);
    end
    rx_hold_cnt--;
    case (rx_mode)
      RX_FLOW:   m_tready <= 1'b1;
      RX_HOLD:   m_tready <= 1'b0;
      default:   m_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no word moved for %0d cycles", idle_cycles);
      $display("bootloader_packet_deframer_crc16_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one link byte and returns at the edge where it is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk_i); while (!s_tready);
    burst_left--;
    bytes_sent++;
  endtask

  // Sends header and length, and for a legal length the payload and CRC.
  task automatic send_frame(input int unsigned len, input bit force_lead,
                            input logic [7:0] lead, input bit spoil_crc);
    logic [bpd_pkg::CRC_W-1:0] crc;
    logic [7:0]                b;
    crc = bpd_pkg::CRC_SEED;
    send_byte(bpd_pkg::HDR_BYTE);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (len != 0 && len <= MAX_PAYLOAD) begin
      for (int unsigned i = 0; i < len; i++) begin
        b = 8'($urandom_range(0, 255));
        if (i == 0 && force_lead) begin
          b = lead;
        end
        crc = bpd_pkg::crc_feed(crc, b);
        send_byte(b);
      end
      if (spoil_crc) begin
        crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
      end
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
    end
  endtask

  initial begin
    int          pick;
    int unsigned len;
    int          stop_at;
    logic [7:0]  b;
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    m_tready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: bad headers, zero and oversize lengths, then one frame of
    // each outcome with a one-byte payload.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(0, 1'b0, 8'h00, 1'b0);
    send_frame(MAX_PAYLOAD + 1, 1'b0, 8'h00, 1'b0);
    send_frame(16'hFFFF, 1'b0, 8'h00, 1'b0);
    send_frame(1, 1'b1, 8'h00, 1'b0);
    send_frame(1, 1'b1, 8'h5A, 1'b0);
    send_frame(1, 1'b1, 8'hFF, 1'b1);

    // Random: mostly good frames, some broken ones and some line noise.
    stop_at = bytes_sent + RANDOM_BYTES;
    send_frame(MAX_PAYLOAD, 1'b0, 8'h00, 1'b0);
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(0, 99);
        if (len < 1) begin
          len = MAX_PAYLOAD;
        end else if (len < 7) begin
          len = $urandom_range(17, 64);
        end else begin
          len = $urandom_range(1, 16);
        end
        send_frame(len, ($urandom_range(0, 3) == 0), {4'h5, 4'($urandom_range(0, 15))},
                   1'b0);
      end else if (pick < 80) begin
        send_frame($urandom_range(1, 16), 1'b0, 8'h00, 1'b1);
      end else if (pick < 85) begin
        send_frame(0, 1'b0, 8'h00, 1'b0);
      end else if (pick < 90) begin
        len = ($urandom_range(0, 3) == 0) ? MAX_PAYLOAD + 1 : $urandom_range(261, 16'hFFFF);
        send_frame(len, 1'b0, 8'h00, 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          do b = 8'($urandom_range(0, 255)); while (b == bpd_pkg::HDR_BYTE);
          send_byte(b);
        end
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d link bytes; %0d payload words passed through.",
             bytes_sent, payload_words);
    $display("Frames accepted: %0d, accepted as PI: %0d, rejected: %0d.",
             accepts, pi_accepts, rejects);
    if (fails == 0 && pending == 0) begin
      $display("bootloader_packet_deframer_crc16_test OK");
    end else begin
      $display("bootloader_packet_deframer_crc16_test NOT OK");
    end
    $finish;
  end

endmodule
